### src/laserdisc_vbi_sequence_checker_top_assert.svh
// ----------------------------------------------------------------------------
// laserdisc vbi sequence checker assertion macros
// shared property forms for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef LASERDISC_VBI_SEQUENCE_CHECKER_TOP_ASSERT_SVH
`define LASERDISC_VBI_SEQUENCE_CHECKER_TOP_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define LVSC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define LVSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/lvsc_pkg.sv
// ----------------------------------------------------------------------------
// lvsc_pkg
// types, codes and the frame number decode for the vbi sequence checker
// ----------------------------------------------------------------------------
package lvsc_pkg;

    localparam logic [23:0] CODE_LEADIN  = 24'h88ffff;
    localparam logic [23:0] CODE_LEADOUT = 24'h80eeee;
    localparam logic [23:0] FRAME_MASK   = 24'hf80000;

    localparam logic [11:0] CAD_22 = 12'h222;
    localparam logic [11:0] CAD_32 = 12'h323;
    localparam logic [11:0] CAD_23 = 12'h232;

    // lead-in event codes
    localparam logic [1:0] LEADIN_NONE        = 2'd0;
    localparam logic [1:0] LEADIN_FIRST       = 2'd1;
    localparam logic [1:0] LEADIN_AFTER_FRAME = 2'd2;

    // lead-out event codes
    localparam logic [1:0] LEADOUT_NONE         = 2'd0;
    localparam logic [1:0] LEADOUT_AFTER_FRAME  = 2'd1;
    localparam logic [1:0] LEADOUT_NO_FRAME     = 2'd2;
    localparam logic [1:0] LEADOUT_REPEAT       = 2'd3;

    // frame event codes
    localparam logic [1:0] FRAME_CONSEC     = 2'd0;
    localparam logic [1:0] FRAME_FIRST_ONE  = 2'd1;
    localparam logic [1:0] FRAME_FIRST_OTHR = 2'd2;
    localparam logic [1:0] FRAME_GAP        = 2'd3;

    // cadence event codes
    localparam logic [2:0] CAD_EV_NONE    = 3'd0;
    localparam logic [2:0] CAD_EV_22      = 3'd1;
    localparam logic [2:0] CAD_EV_32      = 3'd2;
    localparam logic [2:0] CAD_EV_23      = 3'd3;
    localparam logic [2:0] CAD_EV_UNKNOWN = 3'd4;
    localparam logic [2:0] CAD_EV_MISSED  = 3'd5;

    // cadence lock
    typedef enum logic [2:0] {
        LOCK_NONE = 3'b001,
        LOCK_FOUR = 3'b010,
        LOCK_FIVE = 3'b100
    } lock_t;

    typedef struct packed {
        logic [23:0] line17_code;
        logic [23:0] line18_code;
        logic [23:0] chosen_code;
        logic        white_flag;
    } item_t;

    typedef struct packed {
        logic        line_mismatch;
        logic [1:0]  leadin_event;
        logic [1:0]  leadout_event;
        logic        frame_valid;
        logic [16:0] frame_number;
        logic [1:0]  frame_event;
        logic        no_leadin_warning;
        logic [16:0] prior_frame;
        logic        first_white;
        logic [2:0]  cadence_event;
        logic [11:0] spacing_history;
        logic        open_leadin;
    } result_t;

    // five bcd digits, top digit 3 bits, nibbles above 9 taken as given
    function automatic logic [16:0] decode_frame(input logic [23:0] c);
        logic [16:0] sum;
        sum = 17'(c[3:0])
            + 17'(c[7:4]) * 17'd10
            + 17'(c[11:8]) * 17'd100
            + 17'(c[15:12]) * 17'd1000
            + 17'(c[18:16]) * 17'd10000;
        return sum;
    endfunction

endpackage

### src/lvsc_tracker.sv
// ----------------------------------------------------------------------------
// lvsc_tracker
// sequence state and per-field checks; state commits on update
// ----------------------------------------------------------------------------
module lvsc_tracker (
    input  logic             clk,
    input  logic             rst_n,
    input  lvsc_pkg::item_t  item,
    input  logic             update,
    output lvsc_pkg::result_t result
);

    logic               seen_leadin_reg, seen_leadin_next;
    logic               seen_leadout_reg, seen_leadout_next;
    logic               have_frame_reg, have_frame_next;
    logic [16:0]        last_frame_reg, last_frame_next;
    logic               white_seen_reg, white_seen_next;
    logic               have_prev_white_reg, have_prev_white_next;
    logic [3:0]         prev_white_phase_reg, prev_white_phase_next;
    logic [3:0]         field_phase_reg, field_phase_next;
    lvsc_pkg::lock_t    lock_reg, lock_next, lock_mid;
    logic [11:0]        history_reg, history_next, hist;

    logic               is_leadin;
    logic               is_leadout;
    logic               is_frame;
    logic [16:0]        fnum;
    logic [3:0]         spacing;
    logic               missed;

    assign is_leadin  = (item.chosen_code == lvsc_pkg::CODE_LEADIN);
    assign is_leadout = (item.chosen_code == lvsc_pkg::CODE_LEADOUT);
    assign is_frame   = ((item.chosen_code & lvsc_pkg::FRAME_MASK) == lvsc_pkg::FRAME_MASK);
    assign fnum       = lvsc_pkg::decode_frame(item.chosen_code);
    assign spacing    = field_phase_reg - prev_white_phase_reg;

    always_comb
    begin
        seen_leadin_next      = seen_leadin_reg;
        seen_leadout_next     = seen_leadout_reg;
        have_frame_next       = have_frame_reg;
        last_frame_next       = last_frame_reg;
        white_seen_next       = white_seen_reg;
        have_prev_white_next  = have_prev_white_reg;
        prev_white_phase_next = prev_white_phase_reg;
        field_phase_next      = field_phase_reg + 4'd1;
        lock_next             = lock_reg;
        lock_mid              = lock_reg;
        history_next          = history_reg;
        hist                  = history_reg;
        missed                = 1'b0;

        result = '0;
        result.line_mismatch = (item.line17_code != 24'd0) && (item.line18_code != 24'd0)
                               && (item.line17_code != item.line18_code);
        result.prior_frame   = have_frame_reg ? last_frame_reg : 17'd0;

        // lead-in
        if (is_leadin)
        begin
            if (have_frame_reg)
                result.leadin_event = lvsc_pkg::LEADIN_AFTER_FRAME;
            else if (!seen_leadin_reg)
                result.leadin_event = lvsc_pkg::LEADIN_FIRST;
            seen_leadin_next = 1'b1;
        end

        // lead-out
        if (is_leadout)
        begin
            if (!seen_leadout_reg)
            begin
                seen_leadout_next    = 1'b1;
                result.leadout_event = have_frame_reg ? lvsc_pkg::LEADOUT_AFTER_FRAME
                                                      : lvsc_pkg::LEADOUT_NO_FRAME;
            end
            else if (!have_frame_reg)
            begin
                result.leadout_event = lvsc_pkg::LEADOUT_REPEAT;
            end
        end

        // frame number
        if (is_frame)
        begin
            result.frame_valid  = 1'b1;
            result.frame_number = fnum;
            if (!seen_leadin_reg)
            begin
                result.no_leadin_warning = 1'b1;
                seen_leadin_next         = 1'b1;
            end
            if (!have_frame_reg)
                result.frame_event = (fnum == 17'd1) ? lvsc_pkg::FRAME_FIRST_ONE
                                                     : lvsc_pkg::FRAME_FIRST_OTHR;
            else if ({1'b0, fnum} != ({1'b0, last_frame_reg} + 18'd1))
                result.frame_event = lvsc_pkg::FRAME_GAP;
            last_frame_next = fnum;
            have_frame_next = 1'b1;
        end

        // white flag and cadence
        if (item.white_flag)
        begin
            if (!white_seen_reg)
            begin
                white_seen_next    = 1'b1;
                result.first_white = 1'b1;
            end
            if (have_frame_next && !seen_leadout_next)
            begin
                if (have_prev_white_reg)
                    hist = {history_reg[7:0], spacing};
                prev_white_phase_next = field_phase_reg;
                have_prev_white_next  = 1'b1;

                if ((lock_reg == lvsc_pkg::LOCK_NONE) && (hist[11:8] != 4'd0))
                begin
                    priority if (hist == lvsc_pkg::CAD_22)
                    begin
                        result.cadence_event = lvsc_pkg::CAD_EV_22;
                        lock_mid             = lvsc_pkg::LOCK_FOUR;
                    end
                    else if (hist == lvsc_pkg::CAD_32)
                    begin
                        result.cadence_event = lvsc_pkg::CAD_EV_32;
                        lock_mid             = lvsc_pkg::LOCK_FIVE;
                    end
                    else if (hist == lvsc_pkg::CAD_23)
                    begin
                        result.cadence_event = lvsc_pkg::CAD_EV_23;
                        lock_mid             = lvsc_pkg::LOCK_FIVE;
                    end
                    else
                    begin
                        result.cadence_event = lvsc_pkg::CAD_EV_UNKNOWN;
                    end
                end

                unique case (lock_mid)
                    lvsc_pkg::LOCK_NONE: missed = 1'b0;
                    lvsc_pkg::LOCK_FOUR: missed = (hist != lvsc_pkg::CAD_22);
                    lvsc_pkg::LOCK_FIVE: missed = (hist != lvsc_pkg::CAD_32)
                                                  && (hist != lvsc_pkg::CAD_23);
                    default:             missed = 1'b0;
                endcase

                if (missed)
                begin
                    result.cadence_event = lvsc_pkg::CAD_EV_MISSED;
                    lock_next            = lvsc_pkg::LOCK_NONE;
                    history_next         = 12'd0;
                end
                else
                begin
                    lock_next    = lock_mid;
                    history_next = hist;
                end
            end
        end

        result.spacing_history = history_next;
        result.open_leadin     = seen_leadin_next && !seen_leadout_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_leadin_reg      <= 1'b0;
            seen_leadout_reg     <= 1'b0;
            have_frame_reg       <= 1'b0;
            last_frame_reg       <= 17'd0;
            white_seen_reg       <= 1'b0;
            have_prev_white_reg  <= 1'b0;
            prev_white_phase_reg <= 4'd0;
            field_phase_reg      <= 4'd0;
            lock_reg             <= lvsc_pkg::LOCK_NONE;
            history_reg          <= 12'd0;
        end
        else if (update)
        begin
            seen_leadin_reg      <= seen_leadin_next;
            seen_leadout_reg     <= seen_leadout_next;
            have_frame_reg       <= have_frame_next;
            last_frame_reg       <= last_frame_next;
            white_seen_reg       <= white_seen_next;
            have_prev_white_reg  <= have_prev_white_next;
            prev_white_phase_reg <= prev_white_phase_next;
            field_phase_reg      <= field_phase_next;
            lock_reg             <= lock_next;
            history_reg          <= history_next;
        end
    end

endmodule

### src/laserdisc_vbi_sequence_checker_top.sv
// ----------------------------------------------------------------------------
// laserdisc_vbi_sequence_checker_top
// per-field vbi sequence checker: lead-in/out, frame numbers, white flag cadence
// ----------------------------------------------------------------------------
// usage
//   input channel: one transfer per video field, carrying the line 17 and
//   line 18 words, the chosen word and the white flag (in_valid / in_stall)
//   output channel: exactly one result transfer per input transfer, in order
//   (out_valid / out_stall)
//   path: a field taken into the input register is checked from there and its
//   result is loaded into the output register when it advances, and out_valid
//   is up once the result is loaded
//   throughput: one field per cycle unless stalled, set by the single pass
//   from the input register through the checks into the output register
//   stall: while the output register holds an unread result and out_stall is
//   high, the input register holds its field and in_stall rises once it is
//   full; no result is dropped or repeated
//   reset: rst_n clears all sequence state, the cadence lock and both valid
//   flags; the block is ready for a field in the first cycle after reset
// ----------------------------------------------------------------------------
`include "laserdisc_vbi_sequence_checker_top_assert.svh"

module laserdisc_vbi_sequence_checker_top (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [23:0] line17_code,
    input  logic [23:0] line18_code,
    input  logic [23:0] chosen_code,
    input  logic        white_flag,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        line_mismatch,
    output logic [1:0]  leadin_event,
    output logic [1:0]  leadout_event,
    output logic        frame_valid,
    output logic [16:0] frame_number,
    output logic [1:0]  frame_event,
    output logic        no_leadin_warning,
    output logic [16:0] prior_frame,
    output logic        first_white,
    output logic [2:0]  cadence_event,
    output logic [11:0] spacing_history,
    output logic        open_leadin
);

    // input register
    logic              in_valid_reg;
    lvsc_pkg::item_t   item_reg;

    // output register
    logic              out_valid_reg;
    lvsc_pkg::result_t res_reg;
    lvsc_pkg::result_t res_next;

    logic              advance;
    logic              in_take;

    // field moves on when the output register is empty or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.line17_code <= line17_code;
            item_reg.line18_code <= line18_code;
            item_reg.chosen_code <= chosen_code;
            item_reg.white_flag  <= white_flag;
        end
    end

    // checks and sequence state, committed on advance
    lvsc_tracker u_tracker (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_reg),
        .update (advance),
        .result (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid         = out_valid_reg;
    assign line_mismatch     = res_reg.line_mismatch;
    assign leadin_event      = res_reg.leadin_event;
    assign leadout_event     = res_reg.leadout_event;
    assign frame_valid       = res_reg.frame_valid;
    assign frame_number      = res_reg.frame_number;
    assign frame_event       = res_reg.frame_event;
    assign no_leadin_warning = res_reg.no_leadin_warning;
    assign prior_frame       = res_reg.prior_frame;
    assign first_white       = res_reg.first_white;
    assign cadence_event     = res_reg.cadence_event;
    assign spacing_history   = res_reg.spacing_history;
    assign open_leadin       = res_reg.open_leadin;

    // a checked field always lands in the output register
    `LVSC_ASSERT_NEXT(a_advance_fills_out, clk, rst_n, advance, out_valid_reg,
                      "result lost on advance")

    // a missed cadence clears the spacing history
    `LVSC_ASSERT_IMPLY(a_missed_clears_hist, clk, rst_n,
                       out_valid_reg && (res_reg.cadence_event == lvsc_pkg::CAD_EV_MISSED),
                       res_reg.spacing_history == 12'd0,
                       "history kept after missed cadence")

    // missing lead-in warning only comes with a frame code
    `LVSC_ASSERT_IMPLY(a_warn_needs_frame, clk, rst_n,
                       out_valid_reg && res_reg.no_leadin_warning, res_reg.frame_valid,
                       "lead-in warning without frame code")

    // after a first lead-out that follows a frame code the lead-in is closed
    `LVSC_ASSERT_IMPLY(a_leadout_closes, clk, rst_n,
                       out_valid_reg
                       && (res_reg.leadout_event == lvsc_pkg::LEADOUT_AFTER_FRAME),
                       !res_reg.open_leadin, "lead-in still open after lead-out")

endmodule
